// ===== hw/rtl/sire_pkg.sv =====
// shared types and constants of the sorted id range encoder
package sire_pkg;

  localparam int ID_W   = 32;
  localparam int HALF_W = 16;
  localparam int ROW_W  = 16;
  localparam int OFS_W  = 16;
  localparam int KIND_W = 2;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_HEADER   = 2'd0;
  localparam kind_t KIND_COUNT    = 2'd1;
  localparam kind_t KIND_ENDPOINT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROC,
    ST_GAP,
    ST_STORE,
    ST_HDR,
    ST_CNT,
    ST_EP
  } state_t;

endpackage

// ===== hw/rtl/sorted_id_range_encoder.sv =====
// sorted id range encoder: groups ids by high half, merges low-half runs into ranges
//
//   channel | signals                                      | dir | meaning
//   --------+----------------------------------------------+-----+---------------------------
//   in      | in_valid in_ready id_value list_end list_id  | in  | one id word of a sorted list
//   out     | out_valid out_ready code_word word_kind      | out | one word of the encoded list
//           | word_offset row_id row_done overflowed       |     |
//
// an id extending the open range is accepted, then updated; a new range adds a gap step
// an id that closes a group is accepted, decided and stores the last end, then emits the
// header, count and endpoint words, endpoints streaming through the registered read port;
// a changed high half reopens from decide, so such an id on a list end closes two groups
// input is accepted only in idle; a stalled output holds the drain without losing words
// synchronous reset clears all control state; the endpoint memory needs no clearing
module sorted_id_range_encoder
  import sire_pkg::*;
#(
  parameter int MAX_ENDPOINTS = 28
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ID_W-1:0]   id_value,
  input  logic              list_end,
  input  logic [ROW_W-1:0]  list_id,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [HALF_W-1:0] code_word,
  output logic [KIND_W-1:0] word_kind,
  output logic [OFS_W-1:0]  word_offset,
  output logic [ROW_W-1:0]  row_id,
  output logic              row_done,
  output logic              overflowed
);

  localparam int CNT_W  = $clog2(MAX_ENDPOINTS + 1);
  localparam int ADDR_W = $clog2(MAX_ENDPOINTS);

  // control state
  state_t             state, state_next;
  logic               grp_open, grp_open_next;
  logic [HALF_W-1:0]  cur_high, cur_high_next;
  logic [HALF_W-1:0]  prev_low, prev_low_next;
  logic [CNT_W-1:0]   ep_count, ep_count_next;
  logic [OFS_W-1:0]   next_offset, next_offset_next;
  logic               ovf_seen, ovf_seen_next;
  logic               cl_done, cl_done_next;
  logic [CNT_W-1:0]   ep_idx, ep_idx_next;

  // latched input word
  logic [HALF_W-1:0]  item_high, item_low;
  logic               item_last;
  logic [ROW_W-1:0]   item_row;

  // endpoint memory, one write and one registered read port
  logic [HALF_W-1:0]  ep_mem [MAX_ENDPOINTS];
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [HALF_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0]  rd_addr;
  logic [HALF_W-1:0]  rd_data;

  // output word staging
  logic               can_emit;
  logic               emit;
  logic [HALF_W-1:0]  emit_word;
  kind_t              emit_kind;
  logic               emit_done;

  logic               in_take;
  logic               gap;
  logic               fits;
  logic               last_ep;

  assign in_ready = (state == ST_IDLE);
  assign in_take  = in_valid && in_ready;
  assign can_emit = !out_valid || out_ready;

  // a low half beyond previous_low + 1 starts a new range
  assign gap  = {1'b0, item_low} > ({1'b0, prev_low} + (HALF_W+1)'(1));
  // new range needs room for its start and the open range's end plus a closing end
  assign fits = ({1'b0, ep_count} + (CNT_W+1)'(3)) <= (CNT_W+1)'(MAX_ENDPOINTS);
  assign last_ep = (ep_idx + CNT_W'(1)) == ep_count;

  always_comb begin
    state_next       = state;
    grp_open_next    = grp_open;
    cur_high_next    = cur_high;
    prev_low_next    = prev_low;
    ep_count_next    = ep_count;
    next_offset_next = next_offset;
    ovf_seen_next    = ovf_seen;
    cl_done_next     = cl_done;
    ep_idx_next      = ep_idx;
    mem_we           = 1'b0;
    mem_waddr        = ep_count[ADDR_W-1:0];
    mem_wdata        = prev_low;
    emit             = 1'b0;
    emit_word        = cur_high;
    emit_kind        = KIND_HEADER;
    emit_done        = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_take) begin
          state_next = ST_PROC;
        end
      end

      ST_PROC: begin
        if (!grp_open) begin
          // open a group with a single-point range at the low half
          mem_we        = 1'b1;
          mem_waddr     = '0;
          mem_wdata     = item_low;
          ep_count_next = CNT_W'(1);
          cur_high_next = item_high;
          prev_low_next = item_low;
          grp_open_next = 1'b1;
          if (item_last) begin
            cl_done_next = 1'b1;
            state_next   = ST_STORE;
          end else begin
            state_next = ST_IDLE;
          end
        end else if (item_high != cur_high) begin
          // high half changed: drain the group, then reopen from here
          cl_done_next = 1'b0;
          state_next   = ST_STORE;
        end else if (gap && fits) begin
          // end of the open range first, start of the new one next cycle
          mem_we        = 1'b1;
          ep_count_next = ep_count + CNT_W'(1);
          state_next    = ST_GAP;
        end else begin
          if (gap) begin
            ovf_seen_next = 1'b1;
          end else begin
            prev_low_next = item_low;
          end
          if (item_last) begin
            cl_done_next = 1'b1;
            state_next   = ST_STORE;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end

      ST_GAP: begin
        mem_we        = 1'b1;
        mem_wdata     = item_low;
        ep_count_next = ep_count + CNT_W'(1);
        prev_low_next = item_low;
        if (item_last) begin
          cl_done_next = 1'b1;
          state_next   = ST_STORE;
        end else begin
          state_next = ST_IDLE;
        end
      end

      ST_STORE: begin
        // close the open range; always fits, the count stays odd while open
        mem_we        = 1'b1;
        ep_count_next = ep_count + CNT_W'(1);
        ep_idx_next   = '0;
        state_next    = ST_HDR;
      end

      ST_HDR: begin
        if (can_emit) begin
          emit             = 1'b1;
          next_offset_next = next_offset + OFS_W'(1);
          state_next       = ST_CNT;
        end
      end

      ST_CNT: begin
        emit_word = HALF_W'(ep_count);
        emit_kind = KIND_COUNT;
        if (can_emit) begin
          emit             = 1'b1;
          next_offset_next = next_offset + OFS_W'(1);
          state_next       = ST_EP;
        end
      end

      ST_EP: begin
        emit_word = rd_data;
        emit_kind = KIND_ENDPOINT;
        emit_done = cl_done && last_ep;
        if (can_emit) begin
          emit             = 1'b1;
          ep_idx_next      = ep_idx + CNT_W'(1);
          next_offset_next = next_offset + OFS_W'(1);
          if (last_ep) begin
            ep_count_next = '0;
            grp_open_next = 1'b0;
            if (cl_done) begin
              next_offset_next = '0;
              state_next       = ST_IDLE;
            end else begin
              state_next = ST_PROC;
            end
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // read ahead so the data for the current index is ready after each step
  always_comb begin
    if (ep_idx_next < CNT_W'(MAX_ENDPOINTS)) begin
      rd_addr = ep_idx_next[ADDR_W-1:0];
    end else begin
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ep_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= ep_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_open    <= 1'b0;
      cur_high    <= '0;
      prev_low    <= '0;
      ep_count    <= '0;
      next_offset <= '0;
      ovf_seen    <= 1'b0;
      cl_done     <= 1'b0;
      ep_idx      <= '0;
      out_valid   <= 1'b0;
    end else begin
      grp_open    <= grp_open_next;
      cur_high    <= cur_high_next;
      prev_low    <= prev_low_next;
      ep_count    <= ep_count_next;
      next_offset <= next_offset_next;
      ovf_seen    <= ovf_seen_next;
      cl_done     <= cl_done_next;
      ep_idx      <= ep_idx_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_high <= id_value[ID_W-1:HALF_W];
      item_low  <= id_value[HALF_W-1:0];
      item_last <= list_end;
      item_row  <= list_id;
    end
    if (emit) begin
      code_word   <= emit_word;
      word_kind   <= emit_kind;
      word_offset <= next_offset;
      row_id      <= item_row;
      row_done    <= emit_done;
      overflowed  <= ovf_seen;
    end
  end

endmodule

// ===== dv/sorted_id_range_encoder_checker.sv =====
// checker for the sorted id range encoder: predicts each encoded word and compares it
module sorted_id_range_encoder_checker
  import sire_pkg::*;
#(
  parameter int MAX_ENDPOINTS = 28
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [ID_W-1:0]   id_value,
  input  logic              list_end,
  input  logic [ROW_W-1:0]  list_id,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [HALF_W-1:0] code_word,
  input  logic [KIND_W-1:0] word_kind,
  input  logic [OFS_W-1:0]  word_offset,
  input  logic [ROW_W-1:0]  row_id,
  input  logic              row_done,
  input  logic              overflowed,
  output int                mismatches,
  output int                words_pending
);

  typedef struct packed {
    logic [HALF_W-1:0] word;
    kind_t             kind;
    logic [OFS_W-1:0]  ofs;
    logic [ROW_W-1:0]  row;
    logic              done;
    logic              ovf;
  } enc_word_t;

  enc_word_t         expected_words[$];

  // mirror of the encoder state
  logic              grp_open;
  logic [HALF_W-1:0] grp_high;
  logic [HALF_W-1:0] last_low;
  logic [HALF_W-1:0] ep_mem[MAX_ENDPOINTS];
  logic [4:0]        ep_cnt;
  logic [OFS_W-1:0]  ofs_next;
  logic              ovf_sticky;

  function automatic void push_endpoint(logic [HALF_W-1:0] v);
    if (int'(ep_cnt) < MAX_ENDPOINTS) begin
      ep_mem[ep_cnt] = v;
      ep_cnt = ep_cnt + 5'd1;
    end else begin
      ovf_sticky = 1'b1;
    end
  endfunction

  function automatic void emit_word(logic [HALF_W-1:0] w, kind_t k, logic [ROW_W-1:0] row,
                                    logic done);
    enc_word_t e;
    e.word = w;
    e.kind = k;
    e.ofs  = ofs_next;
    e.row  = row;
    e.done = done;
    e.ovf  = ovf_sticky;
    expected_words.insert(expected_words.size(), e);
    ofs_next = ofs_next + 16'd1;
  endfunction

  function automatic void close_group(logic [ROW_W-1:0] row, logic done);
    int total;
    push_endpoint(last_low);
    total = int'(ep_cnt);
    emit_word(grp_high, KIND_HEADER, row, 1'b0);
    emit_word(HALF_W'(total), KIND_COUNT, row, done && total == 0);
    for (int k = 0; k < total && k < MAX_ENDPOINTS; k++)
      emit_word(ep_mem[k], KIND_ENDPOINT, row, done && k + 1 == total);
    ep_cnt   = '0;
    grp_open = 1'b0;
  endfunction

  function automatic void open_group(logic [HALF_W-1:0] high, logic [HALF_W-1:0] low);
    ep_cnt   = '0;
    grp_high = high;
    last_low = low;
    push_endpoint(low);
    grp_open = 1'b1;
  endfunction

  function automatic void encode_id(logic [ID_W-1:0] id, logic is_last, logic [ROW_W-1:0] row);
    logic [HALF_W-1:0] high;
    logic [HALF_W-1:0] low;
    high = id[ID_W-1:HALF_W];
    low  = id[HALF_W-1:0];
    if (!grp_open) begin
      open_group(high, low);
    end else if (high != grp_high) begin
      close_group(row, 1'b0);
      open_group(high, low);
    end else if (32'(low) > 32'(last_low) + 32'd1) begin
      if (int'(ep_cnt) + 3 <= MAX_ENDPOINTS) begin
        push_endpoint(last_low);
        push_endpoint(low);
        last_low = low;
      end else begin
        ovf_sticky = 1'b1;
      end
    end else begin
      last_low = low;
    end
    if (is_last) begin
      close_group(row, 1'b1);
      ofs_next = '0;
    end
  endfunction

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_word();
    enc_word_t e;
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected word %h kind %0d offset %h, none expected",
               $time, code_word, word_kind, word_offset);
      mismatches++;
    end else begin
      e = expected_words.pop_front();
      compare_field("code_word", e.word, code_word);
      compare_field("word_kind", 16'(e.kind), 16'(word_kind));
      compare_field("word_offset", e.ofs, word_offset);
      compare_field("row_id", e.row, row_id);
      compare_field("row_done", 16'(e.done), 16'(row_done));
      compare_field("overflowed", 16'(e.ovf), 16'(overflowed));
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      grp_open   = 1'b0;
      grp_high   = '0;
      last_low   = '0;
      ep_cnt     = '0;
      ofs_next   = '0;
      ovf_sticky = 1'b0;
      mismatches = 0;
      expected_words.delete();
    end else begin
      // a word leaving now stems from an earlier id, so check before predicting
      if (out_valid && out_ready) check_word();
      if (in_valid && in_ready) encode_id(id_value, list_end, list_id);
    end
    words_pending = expected_words.size();
  end

endmodule

// ===== dv/sorted_id_range_encoder_tb.sv =====
// testbench top for the sorted id range encoder: stimulus, idling, watchdog and verdict
module sorted_id_range_encoder_tb
  import sire_pkg::*;
();

  localparam int MAX_EP         = 28;
  localparam int WATCHDOG_LIMIT = 1000;   // far above the longest stall plus drain setup
  localparam int DRAIN_CYCLES   = 64;
  localparam int PHASE1_ITEMS   = 200;    // directed part plus random lists without overflow
  localparam int PHASE2_ITEMS   = 420;    // random lists that may overflow a group
  localparam int TAIL_ITEMS     = 48;     // one list of one-id groups, back to back

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [ID_W-1:0]   id_value  = '0;
  logic              list_end  = 1'b0;
  logic [ROW_W-1:0]  list_id   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [HALF_W-1:0] code_word;
  logic [KIND_W-1:0] word_kind;
  logic [OFS_W-1:0]  word_offset;
  logic [ROW_W-1:0]  row_id;
  logic              row_done;
  logic              overflowed;
  int                mismatches;
  int                words_pending;

  // idling strength, 0 (none) to 3; both sides draw against it
  int                idle_weight = 0;
  int                items_sent  = 0;
  int                stall_left  = 0;
  int                quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sorted_id_range_encoder #(.MAX_ENDPOINTS(MAX_EP)) u_dut (.*);

  sorted_id_range_encoder_checker #(.MAX_ENDPOINTS(MAX_EP)) u_checker (.*);

  // receiver side: random stall bursts, one assignment per falling edge
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 7) < idle_weight) begin
      stall_left = $urandom_range(1, 13) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog: cycles in a row with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("sorted_id_range_encoder_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one id word, maybe after a sender gap; called and returns at a falling edge
  task automatic send_id(logic [ID_W-1:0] id, logic is_last, logic [ROW_W-1:0] row);
    int gap;
    if ($urandom_range(0, 7) < idle_weight) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    id_value <= id;
    list_end <= is_last;
    list_id  <= row;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // one sorted list with random content; noise steps break the ordering now and then
  task automatic send_random_list(int max_len, bit allow_dense);
    int                len;
    int                pick;
    bit                dense;
    bit                row_hops;
    logic [ID_W-1:0]   id;
    logic [ROW_W-1:0]  row;
    dense       = allow_dense && $urandom_range(0, 3) == 0;
    len         = dense ? $urandom_range(16, 40) :
                  ($urandom_range(0, 9) == 0) ? $urandom_range(1, max_len) :
                  $urandom_range(1, 8);
    id          = $urandom();
    row         = 16'($urandom());
    row_hops    = $urandom_range(0, 7) == 0;
    idle_weight = $urandom_range(0, 3);
    // dense lists start low so that many ranges fit in one high half
    if (dense) id[HALF_W-1:0] = 16'($urandom_range(0, 255));
    for (int i = 0; i < len; i++) begin
      send_id(id, i == len - 1, row);
      if (row_hops) row = 16'($urandom());
      pick = dense ? $urandom_range(15, 60) : $urandom_range(0, 99);
      if (pick < 15) begin
        id = id + 32'd1;                                  // run continues
      end else if (pick < 25) begin
        id = id;                                          // duplicate id
      end else if (pick < 55) begin
        id = id + $urandom_range(2, 9);                   // new range, same high half
      end else if (pick < 65) begin
        id = id + $urandom_range(10, 40000);              // wide gap, may carry into high
      end else if (pick < 85) begin
        id[ID_W-1:HALF_W] = id[ID_W-1:HALF_W] + 16'($urandom_range(1, 3));
        id[HALF_W-1:0]    = 16'($urandom());              // next group
      end else if (pick < 92) begin
        id = $urandom();                                  // noise, likely out of order
      end else begin
        id = id - $urandom_range(1, 5);                   // low half steps back
      end
    end
  endtask

  initial begin
    logic [ROW_W-1:0] tail_row;
    logic [HALF_W-1:0] tail_high;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extreme ids as one-word lists
    idle_weight = 0;
    send_id(32'h0000_0000, 1'b1, 16'h0000);
    send_id(32'hFFFF_FFFF, 1'b1, 16'hFFFF);

    // a run, a second range, a duplicate, top of the low half, then a new group
    idle_weight = 2;
    send_id(32'h0001_0000, 1'b0, 16'h1234);
    send_id(32'h0001_0001, 1'b0, 16'h1234);
    send_id(32'h0001_0002, 1'b0, 16'h1234);
    send_id(32'h0001_0005, 1'b0, 16'h1234);
    send_id(32'h0001_0005, 1'b0, 16'h1234);
    send_id(32'h0001_FFFF, 1'b0, 16'h1234);
    send_id(32'h0002_0000, 1'b0, 16'h1234);
    send_id(32'h0002_0003, 1'b1, 16'h1234);

    // unsorted: low half goes back inside a group, then the high half goes back
    send_id(32'h0003_0010, 1'b0, 16'h00A5);
    send_id(32'h0003_0005, 1'b0, 16'h00A5);
    send_id(32'h0003_0011, 1'b0, 16'h00A5);
    send_id(32'h0002_0000, 1'b0, 16'h00A5);
    send_id(32'h0002_0001, 1'b1, 16'h00A5);

    // list number changes in the middle of a list
    idle_weight = 3;
    send_id(32'h0004_0000, 1'b0, 16'h0001);
    send_id(32'h0004_0002, 1'b0, 16'h0002);
    send_id(32'h0004_0003, 1'b1, 16'h0003);

    // high half changes on the final id: two groups close on one word
    send_id(32'h0005_0001, 1'b0, 16'h0007);
    send_id(32'h0006_0002, 1'b1, 16'h0007);

    // random lists short enough that no group can overflow
    while (items_sent < PHASE1_ITEMS) send_random_list(12, 1'b0);

    // buffer full: thirteen extra ranges fit, the rest are dropped and the flag sticks
    idle_weight = 1;
    for (int k = 0; k < 18; k++) send_id({16'h0007, 16'(2 * k)}, 1'b0, 16'h0BEE);
    send_id(32'h0007_0023, 1'b0, 16'h0BEE);
    send_id(32'h0008_0000, 1'b1, 16'h0BEE);

    // random lists of any shape, dense ones included
    while (items_sent < PHASE2_ITEMS) send_random_list(40, 1'b1);

    // last part, no idling: one list of one-id groups back to back
    idle_weight = 0;
    tail_row    = 16'($urandom());
    tail_high   = 16'($urandom_range(0, 255));
    for (int i = 0; i < TAIL_ITEMS; i++) begin
      send_id({tail_high, 16'($urandom())}, i == TAIL_ITEMS - 1, tail_row);
      tail_high = tail_high + 16'd1;
    end
    send_id(32'h00FF_1234, 1'b1, tail_row);
    in_valid <= 1'b0;

    // wait for every predicted word, then give stray words a chance to show
    while (words_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && words_pending == 0) begin
      $display("sorted_id_range_encoder_tb OK");
    end else begin
      $display("sorted_id_range_encoder_tb NOT OK");
    end
    $finish;
  end

endmodule
